>>> hw/rtl/framed_packet_byte_parser_unit_assert.svh
// Assertion macros for the framed packet byte parser.
// Used by the top level; no other dependencies.
`ifndef FRAMED_PACKET_BYTE_PARSER_UNIT_ASSERT_SVH
`define FRAMED_PACKET_BYTE_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clk edge outside reset.
`define FPBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framed packet parser check failed");
// Next-cycle implication, checked on every clk edge outside reset.
`define FPBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framed packet parser check failed");
`else
`define FPBP_ASSERT_NOW(label, ante, cons)
`define FPBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/fpbp_pkg.sv
// Shared constants and control/status types for the framed packet parser.
// No dependencies.
`timescale 1ns / 1ps
package fpbp_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] BYTE_START = 8'hAA;
  localparam logic [7:0] BYTE_END   = 8'h55;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_sum;
    logic take_cmd;
    logic take_len;
    logic take_data;
    logic emit_load;
  } fpbp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic byte_is_start;
    logic byte_is_end;
    logic len_too_big;
    logic rx_len_zero;
    logic data_done;
    logic sum_match;
    logic emit_last;
    logic load_ok;
  } fpbp_stat_t;

endpackage

>>> hw/rtl/fpbp_ctrl.sv
// Frame parser controller: phase state machine issuing datapath commands.
// Depends on fpbp_pkg.
`timescale 1ns / 1ps
module fpbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpbp_pkg::fpbp_stat_t stat,
  output fpbp_pkg::fpbp_cmd_t  cmd
);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_CMD   = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_fire;

  assign in_ready = (state != ST_EMIT);
  assign in_fire  = in_valid && in_ready;

  // Decode phase and incoming byte into commands and next phase
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CMD: begin
        if (in_fire) begin
          cmd.take_cmd = 1'b1;
          state_next   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          if (stat.len_too_big) begin
            state_next = ST_START;
          end else begin
            cmd.take_len = 1'b1;
            state_next   = stat.rx_len_zero ? ST_SUM : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.take_data = 1'b1;
          if (stat.data_done) state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (in_fire) state_next = stat.sum_match ? ST_END : ST_START;
      end
      ST_END: begin
        if (in_fire) state_next = stat.byte_is_end ? ST_EMIT : ST_START;
      end
      ST_EMIT: begin
        // Load one result per free slot of the output register
        if (stat.load_ok) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) state_next = ST_START;
        end
      end
      default: begin
        // Wait for a start byte; unused codes behave the same
        if (in_fire) begin
          if (stat.byte_is_start) begin
            cmd.clear_sum = 1'b1;
            state_next    = ST_CMD;
          end else begin
            state_next = ST_START;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/fpbp_datapath.sv
// Frame parser datapath: checksum, counters, held header, payload store
// and the output result register. Depends on fpbp_pkg.
`timescale 1ns / 1ps
module fpbp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  rx_byte,
  input  fpbp_pkg::fpbp_cmd_t         cmd,
  output fpbp_pkg::fpbp_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  command,
  output logic [fpbp_pkg::LEN_W-1:0]  frame_length,
  output logic [fpbp_pkg::IDX_W-1:0]  byte_index,
  output logic [7:0]                  payload_byte,
  output logic                        has_payload,
  output logic                        last
);

  logic [7:0]                 running_sum;
  logic [fpbp_pkg::LEN_W-1:0] payload_count;
  logic [fpbp_pkg::LEN_W-1:0] count_inc;
  logic [7:0]                 held_command;
  logic [fpbp_pkg::LEN_W-1:0] held_length;
  logic [fpbp_pkg::IDX_W-1:0] emit_idx;
  logic [fpbp_pkg::LEN_W-1:0] emit_inc;
  logic                       emit_last;
  logic [7:0]                 payload_store [fpbp_pkg::MAX_LEN];

  assign count_inc = payload_count + fpbp_pkg::LEN_W'(1);
  assign emit_inc  = {1'b0, emit_idx} + fpbp_pkg::LEN_W'(1);
  assign emit_last = (held_length == '0) || (emit_inc == held_length);

  // Status towards the controller
  always_comb begin
    stat.byte_is_start = (rx_byte == fpbp_pkg::BYTE_START);
    stat.byte_is_end   = (rx_byte == fpbp_pkg::BYTE_END);
    stat.len_too_big   = (rx_byte > 8'(fpbp_pkg::MAX_LEN));
    stat.rx_len_zero   = (rx_byte == 8'd0);
    stat.data_done     = (count_inc >= held_length);
    stat.sum_match     = (rx_byte == running_sum);
    stat.emit_last     = emit_last;
    stat.load_ok       = !out_valid || out_ready;
  end

  // Accumulate checksum and hold header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      payload_count <= '0;
      held_command  <= '0;
      held_length   <= '0;
      emit_idx      <= '0;
    end else begin
      if (cmd.clear_sum) running_sum <= '0;
      if (cmd.take_cmd || cmd.take_len || cmd.take_data) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.take_cmd) held_command <= rx_byte;
      if (cmd.take_len) begin
        held_length   <= rx_byte[fpbp_pkg::LEN_W-1:0];
        payload_count <= '0;
        emit_idx      <= '0;
      end
      if (cmd.take_data) payload_count <= count_inc;
      if (cmd.emit_load) emit_idx <= emit_inc[fpbp_pkg::IDX_W-1:0];
    end
  end

  // Write payload bytes into the store
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      payload_store[payload_count[fpbp_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      command      <= held_command;
      frame_length <= held_length;
      byte_index   <= emit_idx;
      has_payload  <= (held_length != '0);
      last         <= emit_last;
      payload_byte <= (held_length != '0) ? payload_store[emit_idx] : 8'd0;
    end
  end

endmodule

>>> hw/rtl/framed_packet_byte_parser_unit.sv
// Usage: one received byte per input item (in_valid/in_ready, rx_byte).
// Frames are 0xAA, command, length, payload, additive checksum, 0x55.
// Results leave on out_valid/out_ready with command, frame_length,
// byte_index, payload_byte, has_payload and last.
// An input byte is taken whenever in_valid is high while the parser scans.
// After a good end byte the parser enters its emit phase and loads the
// output register with one result at a time (n results, or one for an
// empty frame), each once the register is free, taking no input byte
// during that run. The single output register paces the run.
// A bad length, checksum or end byte drops the frame without a result.
// When the receiver stalls, the current result holds and the run pauses;
// after the last result is loaded, input is taken again even while that
// result still waits. Reset returns the parser to hunting for 0xAA
// with no result pending; the payload store is not cleared.
// Depends on fpbp_pkg, fpbp_ctrl, fpbp_datapath and the assertion header.
`timescale 1ns / 1ps
`include "framed_packet_byte_parser_unit_assert.svh"
module framed_packet_byte_parser_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  command,
  output logic [fpbp_pkg::LEN_W-1:0]  frame_length,
  output logic [fpbp_pkg::IDX_W-1:0]  byte_index,
  output logic [7:0]                  payload_byte,
  output logic                        has_payload,
  output logic                        last
);

  fpbp_pkg::fpbp_cmd_t  cmd;
  fpbp_pkg::fpbp_stat_t stat;

  // Phase controller
  fpbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Checksum, store and result register
  fpbp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command      (command),
    .frame_length (frame_length),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .last         (last)
  );

  // A pending non-final result means the run is still going
  `FPBP_ASSERT_NOW(a_run_blocks_input, out_valid && !last, !in_ready)
  // The final payload result sits at the end of the frame
  `FPBP_ASSERT_NOW(a_last_index, out_valid && last && has_payload,
    ({1'b0, byte_index} + fpbp_pkg::LEN_W'(1)) == frame_length)
  // An empty-frame result is a single zero entry
  `FPBP_ASSERT_NOW(a_empty_frame, out_valid && !has_payload,
    (frame_length == '0) && last && (payload_byte == 8'd0) && (byte_index == '0))
  // Payload results never come from a zero-length frame
  `FPBP_ASSERT_NOW(a_payload_len, out_valid && has_payload, frame_length != '0)

endmodule
